FILE: src/mdcs_pkg.sv
// ----------------------------------------------------------------------------
// mdcs_pkg
// Shared constants for the motor drive current stop block: configuration
// register indexes, request codes, fixed field widths and reset values.
// ----------------------------------------------------------------------------
package mdcs_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURRENT_THRESHOLD = 3'd0,
    CFG_SPINUP_TICKS      = 3'd1,
    CFG_PAUSE_TICKS       = 3'd2,
    CFG_SAMPLE_TICKS      = 3'd3,
    CFG_MAX_RESTARTS      = 3'd4,
    CFG_DRIVE_LEVEL       = 3'd5
  } cfg_idx_t;

  // Request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Fixed widths
  localparam int TICK_W    = 16;
  localparam int SAMPLE_W  = 8;
  localparam int RESTART_W = 2;
  localparam int DRIVE_W   = 8;
  localparam int AVG_W     = 16;

  // Reset values of the configuration registers
  localparam int unsigned THRESHOLD_RST = 1638;
  localparam logic [TICK_W-1:0]    SPINUP_RST  = 16'd200;
  localparam logic [TICK_W-1:0]    PAUSE_RST   = 16'd50;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_RST  = 8'd5;
  localparam logic [RESTART_W-1:0] RESTART_RST = 2'd3;
  localparam logic [DRIVE_W-1:0]   LEVEL_RST   = 8'd255;

endpackage

FILE: src/motor_drive_current_stop_core.sv
// ----------------------------------------------------------------------------
// motor_drive_current_stop_core
// DC motor bridge drive with spin-up stall restarts and a filtered current stop.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each item is either a tick carrying
//   one current sample, or a start request carrying direction and timeout.
//   A start while a move is in progress is ignored (reported status only).
//   Result channel (out_valid / out_stall): exactly one result item per input
//   item, in order: bridge duties, busy, done, stop cause, filtered current.
//   Configuration port (cfg_we / cfg_index / cfg_wdata): write only while idle;
//   indexes beyond the register list are dropped.
// Timing:
//   An item passes an input register, then the move state update into the
//   result register. One item per cycle is sustained while the receiver does
//   not stall; the move state registers load in the same cycle as the result
//   register.
//   When the receiver stalls, the result register holds and, if the input
//   register is empty, one more item is taken into it; after that in_stall rises.
// Reset (rst_n low, synchronous): the move goes idle, counters and the average
//   clear, configuration returns to its defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module motor_drive_current_stop_core #(
  parameter int ADC_BITS     = 12,
  parameter int TIMEOUT_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [mdcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mdcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_req_type,
  input  logic                                in_direction,
  input  logic [TIMEOUT_BITS-1:0]             in_timeout_count,
  input  logic [ADC_BITS-1:0]                 in_current_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mdcs_pkg::DRIVE_W-1:0]        out_drive_a,
  output logic [mdcs_pkg::DRIVE_W-1:0]        out_drive_b,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  output logic                                out_stopped_by_current,
  output logic [mdcs_pkg::AVG_W-1:0]          out_filtered_current
);

  localparam int FRAC_BITS = mdcs_pkg::AVG_W - ADC_BITS;
  localparam int CMP_W     = ADC_BITS + 3;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SPINUP = 2'd1,
    PH_PAUSE  = 2'd2,
    PH_RUN    = 2'd3
  } phase_t;

  // Configuration registers
  logic [ADC_BITS-1:0]                thresh_r;
  logic [mdcs_pkg::TICK_W-1:0]        spinup_r;
  logic [mdcs_pkg::TICK_W-1:0]        pause_r;
  logic [mdcs_pkg::SAMPLE_W-1:0]      sample_r;
  logic [mdcs_pkg::RESTART_W-1:0]     max_rst_r;
  logic [mdcs_pkg::DRIVE_W-1:0]       level_r;

  // Input register
  logic                               in_vld_r;
  logic                               req_r;
  logic                               dir_in_r;
  logic [TIMEOUT_BITS-1:0]            tmo_in_r;
  logic [ADC_BITS-1:0]                smp_r;

  // Move state
  phase_t                             phase_r, phase_nxt;
  logic [mdcs_pkg::TICK_W-1:0]        timer_r, timer_nxt;
  logic [mdcs_pkg::RESTART_W-1:0]     rest_r, rest_nxt;
  logic [TIMEOUT_BITS-1:0]            tmo_r, tmo_nxt;
  logic [mdcs_pkg::AVG_W-1:0]         avg_r, avg_nxt;
  logic                               dir_r, dir_nxt;
  logic                               done_nxt;
  logic                               by_cur_nxt;

  // Result register
  logic                               out_vld_r;
  logic [mdcs_pkg::DRIVE_W-1:0]       drv_a_r, drv_a_nxt;
  logic [mdcs_pkg::DRIVE_W-1:0]       drv_b_r, drv_b_nxt;
  logic                               busy_r, done_r, by_cur_r;
  logic [mdcs_pkg::AVG_W-1:0]         favg_r;

  logic                               in_acc;
  logic                               adv;
  logic                               fire;

  logic                               expired;
  logic [mdcs_pkg::TICK_W-1:0]        timer_dec;
  logic [mdcs_pkg::AVG_W-1:0]         limit;
  logic [mdcs_pkg::AVG_W-1:0]         smp_fx;
  logic [mdcs_pkg::AVG_W:0]           avg_sum;
  logic [mdcs_pkg::AVG_W-1:0]         avg_upd;
  logic [TIMEOUT_BITS-1:0]            tmo_dec;
  logic                               stall_hit;
  logic                               stop_now;
  logic                               stop_run;
  logic                               drive_on;

  // Handshake: the result register drains or is empty -> the stage advances
  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // Datapath pieces
  assign expired   = (timer_r <= mdcs_pkg::TICK_W'(1));
  assign timer_dec = timer_r - mdcs_pkg::TICK_W'(1);
  assign limit     = mdcs_pkg::AVG_W'(thresh_r) << FRAC_BITS;
  assign smp_fx    = mdcs_pkg::AVG_W'(smp_r) << FRAC_BITS;
  assign avg_sum   = {1'b0, avg_r} + {1'b0, smp_fx};
  assign avg_upd   = avg_sum[mdcs_pkg::AVG_W:1];
  assign tmo_dec   = tmo_r - TIMEOUT_BITS'(1);
  // sample > 0.8 * threshold, done exactly as 5 * sample > 4 * threshold
  assign stall_hit = (CMP_W'(smp_r) * CMP_W'(5)) > (CMP_W'(thresh_r) << 2);
  // stop test on the state as it stands (entry into run)
  assign stop_now  = (tmo_r == '0) || (avg_r >= limit);
  // stop test after a filter update
  assign stop_run  = (tmo_dec == '0) || (avg_upd >= limit);

  // Next move state for the item in the input register
  always_comb begin
    phase_nxt  = phase_r;
    timer_nxt  = timer_r;
    rest_nxt   = rest_r;
    tmo_nxt    = tmo_r;
    avg_nxt    = avg_r;
    dir_nxt    = dir_r;
    done_nxt   = 1'b0;
    by_cur_nxt = 1'b0;
    if (req_r == mdcs_pkg::REQ_START) begin
      // start: take it only when idle, ignore otherwise
      if (phase_r == PH_IDLE) begin
        dir_nxt   = dir_in_r;
        tmo_nxt   = tmo_in_r;
        avg_nxt   = '0;
        rest_nxt  = max_rst_r;
        phase_nxt = PH_SPINUP;
        timer_nxt = spinup_r;
      end
    end else begin
      case (phase_r)
        PH_SPINUP: begin
          if (!expired) begin
            timer_nxt = timer_dec;
          end else if (stall_hit && rest_r != '0) begin
            // stall at end of spin-up: drop the drive for a pause
            rest_nxt  = rest_r - mdcs_pkg::RESTART_W'(1);
            phase_nxt = PH_PAUSE;
            timer_nxt = pause_r;
          end else if (stop_now) begin
            done_nxt   = 1'b1;
            by_cur_nxt = (tmo_r != '0);
            phase_nxt  = PH_IDLE;
            timer_nxt  = '0;
          end else begin
            phase_nxt = PH_RUN;
            timer_nxt = mdcs_pkg::TICK_W'(sample_r);
          end
        end
        PH_PAUSE: begin
          if (!expired) begin
            timer_nxt = timer_dec;
          end else begin
            phase_nxt = PH_SPINUP;
            timer_nxt = spinup_r;
          end
        end
        PH_RUN: begin
          if (!expired) begin
            timer_nxt = timer_dec;
          end else begin
            // filter interval: average, count the timeout down, test stop
            avg_nxt   = avg_upd;
            tmo_nxt   = tmo_dec;
            timer_nxt = mdcs_pkg::TICK_W'(sample_r);
            if (stop_run) begin
              done_nxt   = 1'b1;
              by_cur_nxt = (tmo_dec != '0);
              phase_nxt  = PH_IDLE;
              timer_nxt  = '0;
            end
          end
        end
        default: begin
          // idle tick: nothing moves
        end
      endcase
    end
  end

  assign drive_on  = (phase_nxt == PH_SPINUP) || (phase_nxt == PH_RUN);
  assign drv_a_nxt = (drive_on && dir_nxt)  ? level_r : '0;
  assign drv_b_nxt = (drive_on && !dir_nxt) ? level_r : '0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= ADC_BITS'(mdcs_pkg::THRESHOLD_RST);
      spinup_r  <= mdcs_pkg::SPINUP_RST;
      pause_r   <= mdcs_pkg::PAUSE_RST;
      sample_r  <= mdcs_pkg::SAMPLE_RST;
      max_rst_r <= mdcs_pkg::RESTART_RST;
      level_r   <= mdcs_pkg::LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mdcs_pkg::CFG_CURRENT_THRESHOLD: thresh_r  <= cfg_wdata[ADC_BITS-1:0];
        mdcs_pkg::CFG_SPINUP_TICKS:      spinup_r  <= cfg_wdata;
        mdcs_pkg::CFG_PAUSE_TICKS:       pause_r   <= cfg_wdata;
        mdcs_pkg::CFG_SAMPLE_TICKS:      sample_r  <= cfg_wdata[mdcs_pkg::SAMPLE_W-1:0];
        mdcs_pkg::CFG_MAX_RESTARTS:      max_rst_r <= cfg_wdata[mdcs_pkg::RESTART_W-1:0];
        mdcs_pkg::CFG_DRIVE_LEVEL:       level_r   <= cfg_wdata[mdcs_pkg::DRIVE_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Input register: load on accept, empty once the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_req_type;
      dir_in_r <= in_direction;
      tmo_in_r <= in_timeout_count;
      smp_r    <= in_current_sample;
    end
  end

  // Move state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      rest_r    <= '0;
      tmo_r     <= '0;
      avg_r     <= '0;
      dir_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      rest_r    <= rest_nxt;
      tmo_r     <= tmo_nxt;
      avg_r     <= avg_nxt;
      dir_r     <= dir_nxt;
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drv_a_r  <= drv_a_nxt;
      drv_b_r  <= drv_b_nxt;
      busy_r   <= (phase_nxt != PH_IDLE);
      done_r   <= done_nxt;
      by_cur_r <= by_cur_nxt;
      favg_r   <= avg_nxt;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_drive_a            = drv_a_r;
  assign out_drive_b            = drv_b_r;
  assign out_busy_res           = busy_r;
  assign out_done_res           = done_r;
  assign out_stopped_by_current = by_cur_r;
  assign out_filtered_current   = favg_r;

endmodule

FILE: src/mdcs_chk.sv
// ----------------------------------------------------------------------------
// mdcs_chk
// Port-level checks of the result channel of the motor drive current stop.
// ----------------------------------------------------------------------------
module mdcs_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic [mdcs_pkg::DRIVE_W-1:0] out_drive_a,
  input logic [mdcs_pkg::DRIVE_W-1:0] out_drive_b,
  input logic                         out_busy_res,
  input logic                         out_done_res,
  input logic                         out_stopped_by_current
);

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a finished move leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_busy_res)
    else $error("done reported while still busy");

  // stop cause only accompanies the end of a move
  a_cause_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stopped_by_current) |-> out_done_res)
    else $error("stop cause without done");

  // bridge is off whenever no move runs
  a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_drive_a == '0 && out_drive_b == '0))
    else $error("drive active while idle");

  // never both sides of the bridge at once
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_a == '0 || out_drive_b == '0))
    else $error("both bridge sides driven");

endmodule

bind motor_drive_current_stop_core mdcs_chk u_mdcs_chk (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_drive_a            (out_drive_a),
  .out_drive_b            (out_drive_b),
  .out_busy_res           (out_busy_res),
  .out_done_res           (out_done_res),
  .out_stopped_by_current (out_stopped_by_current)
);
